// ===== design/bscp_pkg.sv =====
// ----------------------------------------------------------------------------
// bscp_pkg
// Shared types and constants of the bit-sliced column page.
// ----------------------------------------------------------------------------
package bscp_pkg;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 16;
  localparam int ROWIDX_W = 12;
  localparam int WIDX_W   = 6;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 6;
  localparam int ST_W     = 2;
  localparam int RC_W     = 13;
  localparam int DEPTH_W  = 5;
  localparam int LEN_W    = 13;
  localparam int CFG_W    = 13;

  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_ACCESS   = 3'd1;
  localparam logic [OP_W-1:0] OP_SEEK_AND = 3'd2;
  localparam logic [OP_W-1:0] OP_SEEK_OR  = 3'd3;
  localparam logic [OP_W-1:0] OP_SELECT   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_INITIAL_DEPTH = 1'b0;
  localparam logic CFG_START_LENGTH  = 1'b1;

  typedef enum logic [1:0] {
    MODE_AND,
    MODE_OR,
    MODE_ROW,
    MODE_APPEND
  } mode_t;

  typedef struct packed {
    logic               load;
    logic               step;
    mode_t              mode;
    logic [DEPTH_W-1:0] plane;
    logic [POS_W-1:0]   pos;
    logic [KEY_W-1:0]   key;
    logic [WORD_W-1:0]  init;
  } unit_ctrl_t;

endpackage

// ===== design/bscp_in_if.sv =====
// ----------------------------------------------------------------------------
// bscp_in_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface bscp_in_if;
  logic                            valid;
  logic                            ready;
  logic [bscp_pkg::OP_W-1:0]       operation;
  logic [bscp_pkg::KEY_W-1:0]      key;
  logic [bscp_pkg::ROWIDX_W-1:0]   row_index;
  logic [bscp_pkg::WIDX_W-1:0]     word_index;
  logic [bscp_pkg::WORD_W-1:0]     bitmap_word;

  modport source (output valid, operation, key, row_index, word_index, bitmap_word,
                  input ready);
  modport sink (input valid, operation, key, row_index, word_index, bitmap_word,
                output ready);
endinterface

// ===== design/bscp_out_if.sv =====
// ----------------------------------------------------------------------------
// bscp_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface bscp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bscp_pkg::ST_W-1:0]     status;
  logic [bscp_pkg::RC_W-1:0]     row_count;
  logic [bscp_pkg::KEY_W-1:0]    key_value;
  logic [bscp_pkg::WORD_W-1:0]   match_word;
  logic                          last;

  modport source (output valid, status, row_count, key_value, match_word, last,
                  input ready);
  modport sink (input valid, status, row_count, key_value, match_word, last,
                output ready);
endinterface

// ===== design/bit_sliced_column_page.sv =====
// ----------------------------------------------------------------------------
// bit_sliced_column_page
// Bit-sliced column page: one key per row, bit d of each key in plane d.
// ----------------------------------------------------------------------------
// All plane words sit in one memory with a single registered read port, and
// every operation walks its planes through it one word per cycle, the planes
// walked being the new key's bit length for append, min(active, 16) for
// access and the active count for seek. Select scans its selection bits one
// per cycle up to the last set one, pausing while a selected row's
// min(active, 16) planes are walked and its result waits to be taken. Full
// append and empty select answer without walking any plane. After reset and
// after each configuration write the memory is cleared, one word per cycle,
// MAX_PLANES * ceil(ROWS / 64) words (1024 at the defaults); no request is
// accepted meanwhile.
module bit_sliced_column_page #(
  parameter int ROWS       = 4096,
  parameter int MAX_PLANES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bscp_pkg::CFG_W-1:0]   cfg_data,
  bscp_in_if.sink                      in,
  bscp_out_if.source                   out
);

  localparam int PAGE_WORDS = (ROWS + 63) / 64;
  localparam int DEPTH      = MAX_PLANES * PAGE_WORDS;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW         = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
  localparam int RW         = $clog2(ROWS + 1);
  localparam int CW         = ((RW > bscp_pkg::LEN_W) ? RW : bscp_pkg::LEN_W) + 1;
  localparam int DW         = bscp_pkg::DEPTH_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PASS  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                        state;
  logic [DW-1:0]                 initial_depth;
  logic [bscp_pkg::LEN_W-1:0]    start_length;
  logic [RW-1:0]                 rows_held;
  logic [DW-1:0]                 grown_depth;
  logic [AW-1:0]                 clr_addr;
  logic [bscp_pkg::OP_W-1:0]     op_r;
  logic [bscp_pkg::KEY_W-1:0]    key_r;
  logic [bscp_pkg::POS_W-1:0]    pos_r;
  logic [WW-1:0]                 word_r;
  logic [bscp_pkg::WORD_W-1:0]   sel_r;
  logic [DW-1:0]                 planes_r;
  logic [DW-1:0]                 issue_d;
  logic [AW-1:0]                 issue_base;
  logic                          rd_pend;
  logic [DW-1:0]                 cons_plane;
  logic [AW-1:0]                 cons_addr;
  logic [bscp_pkg::ST_W-1:0]     res_status;
  logic [bscp_pkg::RC_W-1:0]     res_rc;
  logic                          res_last;

  logic [WW-1:0]                 wrap_tab [64];
  logic [DW-1:0]                 depth_new;
  logic [bscp_pkg::LEN_W-1:0]    len_new;
  logic [DW-1:0]                 need;
  logic [DW-1:0]                 row_planes;
  logic [CW-1:0]                 rows_ext;
  logic [CW-1:0]                 base_ext;
  logic [CW-1:0]                 diff;
  logic [bscp_pkg::WORD_W-1:0]   lim_mask;
  logic                          accept;
  logic                          issue;
  logic                          out_free;
  logic [AW-1:0]                 raddr;
  logic [bscp_pkg::WORD_W-1:0]   rdata;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [bscp_pkg::WORD_W-1:0]   ram_wdata;
  logic [bscp_pkg::WORD_W-1:0]   acc;
  logic [bscp_pkg::KEY_W-1:0]    row_key;
  logic [bscp_pkg::WORD_W-1:0]   unit_wdata;
  logic                          unit_we;
  bscp_pkg::unit_ctrl_t          ctrl;

  for (genvar g = 0; g < 64; g++) begin : g_wrap
    assign wrap_tab[g] = WW'(g % PAGE_WORDS);
  end

  assign in.ready = (state == S_IDLE);
  assign accept   = in.valid && in.ready;
  assign out_free = !out.valid || out.ready;
  assign issue    = (state == S_PASS) && (issue_d < planes_r);
  assign raddr    = issue_base + AW'(word_r);

  assign depth_new = (cfg_index == bscp_pkg::CFG_INITIAL_DEPTH) ?
                     cfg_data[DW-1:0] : initial_depth;
  assign len_new   = (cfg_index == bscp_pkg::CFG_START_LENGTH) ?
                     cfg_data[bscp_pkg::LEN_W-1:0] : start_length;

  assign row_planes = (grown_depth > DW'(bscp_pkg::KEY_W)) ?
                      DW'(bscp_pkg::KEY_W) : grown_depth;

  always_comb begin
    need = DW'(1);
    for (int i = 1; i < bscp_pkg::KEY_W; i++) begin
      if (in.key[i]) begin
        need = DW'(i + 1);
      end
    end
    if (need > DW'(MAX_PLANES)) begin
      need = DW'(MAX_PLANES);
    end
  end

  assign rows_ext = CW'(rows_held);
  assign base_ext = CW'({in.word_index, 6'b0});
  assign diff     = rows_ext - base_ext;

  always_comb begin
    if (rows_ext <= base_ext) begin
      lim_mask = '0;
    end else if (diff >= CW'(64)) begin
      lim_mask = '1;
    end else begin
      lim_mask = ~({bscp_pkg::WORD_W{1'b1}} << diff[5:0]);
    end
  end

  always_comb begin
    ctrl.load  = 1'b0;
    ctrl.step  = (state == S_PASS) && rd_pend;
    ctrl.plane = cons_plane;
    ctrl.pos   = pos_r;
    ctrl.key   = key_r;
    ctrl.init  = in.bitmap_word;
    case (op_r)
      bscp_pkg::OP_APPEND:   ctrl.mode = bscp_pkg::MODE_APPEND;
      bscp_pkg::OP_SEEK_AND: ctrl.mode = bscp_pkg::MODE_AND;
      bscp_pkg::OP_SEEK_OR:  ctrl.mode = bscp_pkg::MODE_OR;
      default:               ctrl.mode = bscp_pkg::MODE_ROW;
    endcase
    if (accept) begin
      ctrl.load = 1'b1;
      if (in.operation == bscp_pkg::OP_SEEK_OR && grown_depth != '0) begin
        ctrl.init = '0;
      end
    end else if (state == S_SCAN && sel_r[0]) begin
      ctrl.load = 1'b1;
    end
  end

  assign ram_we    = (state == S_CLEAR) || unit_we;
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : cons_addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 : unit_wdata;

  bscp_ram #(
    .WIDTH (bscp_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bscp_plane_unit u_unit (
    .clk     (clk),
    .ctrl    (ctrl),
    .rdata   (rdata),
    .acc     (acc),
    .row_key (row_key),
    .wdata   (unit_wdata),
    .we      (unit_we)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      if (rst) begin
        initial_depth <= '0;
        start_length  <= '0;
        rows_held     <= '0;
        grown_depth   <= '0;
      end else begin
        initial_depth <= depth_new;
        start_length  <= len_new;
        grown_depth   <= (depth_new > DW'(MAX_PLANES)) ? DW'(MAX_PLANES) : depth_new;
        rows_held     <= (CW'(len_new) > CW'(ROWS)) ? RW'(ROWS) : RW'(len_new);
      end
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r       <= in.operation;
            key_r      <= in.key;
            pos_r      <= in.row_index[5:0];
            issue_d    <= '0;
            issue_base <= '0;
            rd_pend    <= 1'b0;
            res_status <= bscp_pkg::ST_OK;
            res_rc     <= '0;
            res_last   <= 1'b1;
            case (in.operation)
              bscp_pkg::OP_APPEND: begin
                if (rows_held == RW'(ROWS)) begin
                  res_status <= bscp_pkg::ST_FULL;
                  res_rc     <= bscp_pkg::RC_W'(rows_held);
                  state      <= S_EMIT;
                end else begin
                  if (grown_depth < need) begin
                    grown_depth <= need;
                  end
                  planes_r  <= need;
                  word_r    <= WW'(rows_held >> 6);
                  pos_r     <= rows_held[5:0];
                  rows_held <= rows_held + RW'(1);
                  res_rc    <= bscp_pkg::RC_W'(rows_held + RW'(1));
                  state     <= S_PASS;
                end
              end
              bscp_pkg::OP_ACCESS: begin
                planes_r <= row_planes;
                word_r   <= wrap_tab[in.row_index[11:6]];
                state    <= S_PASS;
              end
              bscp_pkg::OP_SEEK_AND, bscp_pkg::OP_SEEK_OR: begin
                planes_r <= grown_depth;
                word_r   <= wrap_tab[in.word_index];
                state    <= S_PASS;
              end
              bscp_pkg::OP_SELECT: begin
                planes_r <= row_planes;
                word_r   <= wrap_tab[in.word_index];
                pos_r    <= '0;
                sel_r    <= in.bitmap_word & lim_mask;
                if ((in.bitmap_word & lim_mask) == '0) begin
                  res_status <= bscp_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PASS: begin
          rd_pend    <= issue;
          cons_plane <= issue_d;
          cons_addr  <= raddr;
          if (issue) begin
            issue_d    <= issue_d + DW'(1);
            issue_base <= issue_base + AW'(PAGE_WORDS);
          end else if (!rd_pend) begin
            state <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (sel_r[0]) begin
            issue_d    <= '0;
            issue_base <= '0;
            rd_pend    <= 1'b0;
            res_last   <= (sel_r >> 1) == '0;
            state      <= S_PASS;
          end else begin
            sel_r <= sel_r >> 1;
            pos_r <= pos_r + bscp_pkg::POS_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (op_r == bscp_pkg::OP_SELECT && !res_last) begin
              sel_r <= sel_r >> 1;
              pos_r <= pos_r + bscp_pkg::POS_W'(1);
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out.status    <= res_status;
      out.row_count <= res_rc;
      out.last      <= res_last;
      out.key_value <= ((op_r == bscp_pkg::OP_ACCESS || op_r == bscp_pkg::OP_SELECT) &&
                        res_status == bscp_pkg::ST_OK) ? row_key : '0;
      out.match_word <= (op_r == bscp_pkg::OP_SEEK_AND || op_r == bscp_pkg::OP_SEEK_OR) ?
                        acc : '0;
    end
  end

endmodule

// ===== design/bscp_ram.sv =====
// ----------------------------------------------------------------------------
// bscp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bscp_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bscp_plane_unit.sv =====
// ----------------------------------------------------------------------------
// bscp_plane_unit
// Shared plane unit: folds one plane word per step into the seek word,
// gathers row key bits, or forms the append write-back word.
// ----------------------------------------------------------------------------
module bscp_plane_unit (
  input  logic                           clk,
  input  bscp_pkg::unit_ctrl_t           ctrl,
  input  logic [bscp_pkg::WORD_W-1:0]    rdata,
  output logic [bscp_pkg::WORD_W-1:0]    acc,
  output logic [bscp_pkg::KEY_W-1:0]     row_key,
  output logic [bscp_pkg::WORD_W-1:0]    wdata,
  output logic                           we
);

  logic                        in_key;
  logic                        kbit;
  logic [bscp_pkg::WORD_W-1:0] m;

  assign in_key = ctrl.plane < bscp_pkg::DEPTH_W'(bscp_pkg::KEY_W);
  assign kbit   = in_key && ctrl.key[ctrl.plane[3:0]];
  assign m      = kbit ? rdata : ~rdata;
  assign wdata  = rdata | (bscp_pkg::WORD_W'(1) << ctrl.pos);
  assign we     = ctrl.step && (ctrl.mode == bscp_pkg::MODE_APPEND) && kbit;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc     <= ctrl.init;
      row_key <= '0;
    end else if (ctrl.step) begin
      case (ctrl.mode)
        bscp_pkg::MODE_AND: acc <= acc & m;
        bscp_pkg::MODE_OR:  acc <= acc | m;
        bscp_pkg::MODE_ROW: begin
          if (in_key) begin
            row_key[ctrl.plane[3:0]] <= rdata[ctrl.pos];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bscp_checker.sv =====
// ----------------------------------------------------------------------------
// bscp_checker
// Port-level checks of the column page, bound to the top level.
// ----------------------------------------------------------------------------
module bscp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bscp_pkg::OP_W-1:0]    in_operation,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bscp_pkg::ST_W-1:0]    out_status,
  input logic [bscp_pkg::KEY_W-1:0]   out_key_value,
  input logic                         out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_key_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_busy_after_op: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_operation <= bscp_pkg::OP_SELECT) |=> !in_ready)
    else $error("request taken while an operation is running");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("request taken during page clear");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == bscp_pkg::ST_FULL || out_status == bscp_pkg::ST_EMPTY)
      |-> out_last && (out_key_value == '0))
    else $error("status result not final or carries a key");

endmodule

bind bit_sliced_column_page bscp_checker u_bscp_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .in_valid      (in.valid),
  .in_ready      (in.ready),
  .in_operation  (in.operation),
  .out_valid     (out.valid),
  .out_ready     (out.ready),
  .out_status    (out.status),
  .out_key_value (out.key_value),
  .out_last      (out.last)
);

// ===== tb/tb_bscp_if.sv =====
// ----------------------------------------------------------------------------
// tb_bscp_if
// Interface file of the testbench: the request and result channels come from
// the design folder; this file only holds a small clock-free helper interface
// used to pass the configuration port around.
// ----------------------------------------------------------------------------
interface tb_bscp_cfg_if;
  logic                         we;
  logic                         index;
  logic [bscp_pkg::CFG_W-1:0]   data;

  modport source (output we, index, data);
  modport sink (input we, index, data);
endinterface

// ===== tb/tb_bit_sliced_column_page.sv =====
// ----------------------------------------------------------------------------
// tb_bit_sliced_column_page
// Self-checking bench of the bit-sliced column page. A behavioral copy of the
// page predicts every result of each accepted request; a checker compares the
// results in order, field by field. Directed tests cover the operations and
// corner cases, then random traffic with bad opcodes runs under random stalls.
// ----------------------------------------------------------------------------
module tb_bit_sliced_column_page;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS   = 4096;
  localparam int NPLANES = 16;
  localparam int NWORDS  = NROWS / 64;
  localparam int WDOG    = 40000;

  typedef struct packed {
    logic [bscp_pkg::ST_W-1:0]   status;
    logic [bscp_pkg::RC_W-1:0]   row_count;
    logic [bscp_pkg::KEY_W-1:0]  key_value;
    logic [bscp_pkg::WORD_W-1:0] match_word;
    logic                        last;
  } page_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tb_bscp_cfg_if cfg_ch ();
  bscp_in_if     req_ch ();
  bscp_out_if    res_ch ();

  bit_sliced_column_page i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_ch.we),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in        (req_ch.sink),
    .out       (res_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // page copy
  logic [bscp_pkg::WORD_W-1:0] planes_m [NPLANES][NWORDS];
  int unsigned rows_m, depth_m, init_depth_m, start_len_m;
  page_result_t pending_q[$];

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int idle_pct = 28;
  int stall_pct = 28;
  bit hold_off = 1'b0;
  int quiet = 0;

  task automatic fresh_page();
    foreach (planes_m[d, w]) planes_m[d][w] = '0;
    rows_m  = (start_len_m > NROWS) ? NROWS : start_len_m;
    depth_m = (init_depth_m > NPLANES) ? NPLANES : init_depth_m;
  endtask

  function automatic logic [bscp_pkg::KEY_W-1:0] row_key(int unsigned row);
    logic [bscp_pkg::KEY_W-1:0] k;
    k = '0;
    for (int d = 0; d < depth_m; d++)
      k[d] = planes_m[d][(row / 64) % NWORDS][row % 64];
    return k;
  endfunction

  task automatic predict_page(logic [bscp_pkg::OP_W-1:0] op,
                              logic [bscp_pkg::KEY_W-1:0] key,
                              logic [bscp_pkg::ROWIDX_W-1:0] row,
                              logic [bscp_pkg::WIDX_W-1:0] widx,
                              logic [bscp_pkg::WORD_W-1:0] bm);
    page_result_t r;
    logic [bscp_pkg::WORD_W-1:0] acc, p;
    int unsigned need;
    int n;
    r = '0;
    r.last = 1'b1;
    case (op)
      bscp_pkg::OP_APPEND: begin
        if (rows_m >= NROWS) begin
          r.status = bscp_pkg::ST_FULL;
          r.row_count = bscp_pkg::RC_W'(rows_m);
        end else begin
          need = 1;
          for (int b = 1; b < bscp_pkg::KEY_W; b++) if (key[b]) need = b + 1;
          if (depth_m < need) depth_m = need;
          for (int d = 0; d < depth_m; d++)
            if (key[d]) planes_m[d][(rows_m / 64) % NWORDS][rows_m % 64] = 1'b1;
          rows_m++;
          r.row_count = bscp_pkg::RC_W'(rows_m);
        end
        pending_q.push_back(r);
      end
      bscp_pkg::OP_ACCESS: begin
        r.key_value = row_key(row);
        pending_q.push_back(r);
      end
      bscp_pkg::OP_SEEK_AND, bscp_pkg::OP_SEEK_OR: begin
        acc = (op == bscp_pkg::OP_SEEK_AND) ? bm : '0;
        for (int d = 0; d < depth_m; d++) begin
          p = planes_m[d][widx % NWORDS];
          if (!key[d]) p = ~p;
          acc = (op == bscp_pkg::OP_SEEK_AND) ? (acc & p) : (acc | p);
        end
        if (op == bscp_pkg::OP_SEEK_OR && depth_m == 0) acc = bm;
        r.match_word = acc;
        pending_q.push_back(r);
      end
      bscp_pkg::OP_SELECT: begin
        n = 0;
        for (int b = 0; b < 64; b++) begin
          if (!bm[b]) continue;
          if (widx * 64 + b >= rows_m) break;
          r = '0;
          r.key_value = row_key(widx * 64 + b);
          pending_q.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = '0;
          r.status = bscp_pkg::ST_EMPTY;
          r.last = 1'b1;
          pending_q.push_back(r);
        end else begin
          pending_q[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    cfg_ch.we = 1'b0;
    cfg_ch.index = 1'b0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = '0;
    req_ch.key = '0;
    req_ch.row_index = '0;
    req_ch.word_index = '0;
    req_ch.bitmap_word = '0;
    res_ch.ready = 1'b0;
  end

  task automatic send_item(logic [bscp_pkg::OP_W-1:0] op,
                           logic [bscp_pkg::KEY_W-1:0] key,
                           logic [bscp_pkg::ROWIDX_W-1:0] row,
                           logic [bscp_pkg::WIDX_W-1:0] widx,
                           logic [bscp_pkg::WORD_W-1:0] bm);
    do @(negedge clk); while ($urandom_range(99) < idle_pct);
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.key <= key;
    req_ch.row_index <= row;
    req_ch.word_index <= widx;
    req_ch.bitmap_word <= bm;
    do @(posedge clk); while (!req_ch.ready);
    predict_page(op, key, row, widx, bm);
    n_items++;
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain_page();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    drain_page();
    cfg_ch.we <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= bscp_pkg::CFG_W'(value);
    @(negedge clk);
    cfg_ch.we <= 1'b0;
    if (idx == bscp_pkg::CFG_INITIAL_DEPTH) init_depth_m = value & 5'h1f;
    else start_len_m = value & 13'h1fff;
    fresh_page();
  endtask

  // result side
  always @(negedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    page_result_t got, exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.status, res_ch.row_count, res_ch.key_value,
              res_ch.match_word, res_ch.last};
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
      end else begin
        exp_r = pending_q.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
        if (got.row_count !== exp_r.row_count)
          $display("%0t: row_count exp %0d got %0d", $realtime, exp_r.row_count,
                   got.row_count);
        if (got.key_value !== exp_r.key_value)
          $display("%0t: key_value exp %h got %h", $realtime, exp_r.key_value,
                   got.key_value);
        if (got.match_word !== exp_r.match_word)
          $display("%0t: match_word exp %h got %h", $realtime, exp_r.match_word,
                   got.match_word);
        if (got.last !== exp_r.last)
          $display("%0t: last exp %0d got %0d", $realtime, exp_r.last, got.last);
        if (got !== exp_r) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG) begin
      $display("watchdog: no transaction for %0d cycles", WDOG);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [bscp_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(3))
      0: return bscp_pkg::KEY_W'($urandom_range(15));
      1: return bscp_pkg::KEY_W'($urandom_range(255));
      default: return bscp_pkg::KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [bscp_pkg::WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_basic_ops();
    send_item(bscp_pkg::OP_SELECT, '0, '0, '0, '1);
    send_item(bscp_pkg::OP_SEEK_OR, '0, '0, '0, 64'h0123_4567_89ab_cdef);
    send_item(bscp_pkg::OP_SEEK_AND, '0, '0, '0, '1);
    send_item(bscp_pkg::OP_APPEND, 16'd0, '0, '0, '0);
    send_item(bscp_pkg::OP_APPEND, 16'hffff, '0, '0, '0);
    send_item(bscp_pkg::OP_APPEND, 16'd1, '0, '0, '0);
    send_item(bscp_pkg::OP_APPEND, 16'h8000, '0, '0, '0);
    send_item(bscp_pkg::OP_APPEND, 16'h5a5a, '0, '0, '0);
    send_item(3'd5, 16'hffff, '1, '1, '1);
    send_item(3'd7, '0, '0, '0, '0);
    send_item(bscp_pkg::OP_ACCESS, '0, 12'd1, '0, '0);
    send_item(bscp_pkg::OP_ACCESS, '0, 12'hfff, '0, '0);
    send_item(bscp_pkg::OP_SEEK_AND, 16'hffff, '0, '0, '1);
    send_item(bscp_pkg::OP_SEEK_OR, 16'h8000, '0, 6'd63, '0);
    send_item(bscp_pkg::OP_SELECT, '0, '0, '0, 64'h1f);
    send_item(bscp_pkg::OP_SELECT, '0, '0, '0, 64'hffff_0000_0000_0000);
    send_item(bscp_pkg::OP_SELECT, '0, '0, 6'd63, '1);
    send_item(bscp_pkg::OP_SELECT, '0, '0, '0, '0);
  endtask

  task automatic test_config_edges();
    write_reg(bscp_pkg::CFG_INITIAL_DEPTH, 16);
    write_reg(bscp_pkg::CFG_START_LENGTH, 4095);
    send_item(bscp_pkg::OP_SEEK_OR, 16'h00ff, '0, 6'd63, rand_word());
    send_item(bscp_pkg::OP_APPEND, 16'h00ff, '0, '0, '0);
    send_item(bscp_pkg::OP_APPEND, 16'h1234, '0, '0, '0);
    send_item(bscp_pkg::OP_ACCESS, '0, 12'hfff, '0, '0);
    send_item(bscp_pkg::OP_SELECT, '0, '0, 6'd63, 64'h8000_0000_0000_0001);
    write_reg(bscp_pkg::CFG_INITIAL_DEPTH, 31);
    write_reg(bscp_pkg::CFG_START_LENGTH, 8191);
    send_item(bscp_pkg::OP_APPEND, 16'h0001, '0, '0, '0);
    send_item(bscp_pkg::OP_SEEK_AND, 16'h00ff, '0, 6'd5, '1);
  endtask

  task automatic test_backpressure();
    write_reg(bscp_pkg::CFG_INITIAL_DEPTH, 2);
    write_reg(bscp_pkg::CFG_START_LENGTH, 0);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (12) send_item(bscp_pkg::OP_APPEND, rand_key(), '0, '0, '0);
    join
    drain_page();
    repeat (4) send_item(bscp_pkg::OP_SELECT, '0, '0, '0, rand_word());
  endtask

  task automatic run_random(int count);
    int unsigned r, wl;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) begin idle_pct = 0; stall_pct = 0; end
      if (i == count / 2) begin idle_pct = 28; stall_pct = 28; end
      if (i % 90 == 0) begin
        write_reg(bscp_pkg::CFG_INITIAL_DEPTH, $urandom_range(16));
        write_reg(bscp_pkg::CFG_START_LENGTH, ($urandom_range(3) == 0) ?
                  $urandom_range(4096) : $urandom_range(96));
      end
      wl = (rows_m > 64) ? $urandom_range((rows_m - 1) / 64) : 0;
      r = $urandom_range(99);
      if (r < 30)
        send_item(bscp_pkg::OP_APPEND, rand_key(), '0, '0, '0);
      else if (r < 48)
        send_item(bscp_pkg::OP_ACCESS, '0, ($urandom_range(4) == 0) ?
                  bscp_pkg::ROWIDX_W'($urandom) :
                  bscp_pkg::ROWIDX_W'($urandom_range(rows_m + 1)), '0, '0);
      else if (r < 63)
        send_item(bscp_pkg::OP_SEEK_AND, rand_key(), '0, ($urandom_range(5) == 0)
                  ? bscp_pkg::WIDX_W'($urandom) : bscp_pkg::WIDX_W'(wl), rand_word());
      else if (r < 76)
        send_item(bscp_pkg::OP_SEEK_OR, rand_key(), '0, ($urandom_range(5) == 0)
                  ? bscp_pkg::WIDX_W'($urandom) : bscp_pkg::WIDX_W'(wl), rand_word());
      else if (r < 97)
        send_item(bscp_pkg::OP_SELECT, '0, '0, ($urandom_range(5) == 0)
                  ? bscp_pkg::WIDX_W'($urandom) : bscp_pkg::WIDX_W'(wl),
                  ($urandom_range(2) == 0) ? rand_word()
                  : bscp_pkg::WORD_W'(rand_word() & rand_word() & rand_word()));
      else
        send_item(bscp_pkg::OP_W'($urandom_range(7, 5)), rand_key(),
                  bscp_pkg::ROWIDX_W'($urandom), bscp_pkg::WIDX_W'($urandom),
                  rand_word());
    end
  endtask

  initial begin
    init_depth_m = 0;
    start_len_m = 0;
    fresh_page();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_basic_ops();
    test_config_edges();
    test_backpressure();
    run_random(340);
    drain_page();
    $display("covered %0d requests and %0d results: all operations, config extremes,",
             n_items, n_results);
    $display("full page, empty select, long result stall and random idling");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bscp_pkg.sv
design/bscp_in_if.sv
design/bscp_out_if.sv
design/bscp_ram.sv
design/bscp_plane_unit.sv
design/bit_sliced_column_page.sv
design/bscp_checker.sv
tb/tb_bscp_if.sv
tb/tb_bit_sliced_column_page.sv
